// ===== hdl/idle_gap_frame_receiver_unit_defines.svh =====
// Assertion macros for the idle-gap frame receiver.
// Uses clk_i and rst_ni of the module that includes it; no other dependencies.
`ifndef IDLE_GAP_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define IDLE_GAP_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IGFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define IGFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/igfr_pkg.sv =====
// Shared types and constants of the idle-gap frame receiver.
// No dependencies; imported by the controller, datapath and top level.
package igfr_pkg;

  // Frame buffer geometry (depth may range from 12 to 64)
  localparam int unsigned BUF_DEPTH = 16;
  localparam int unsigned ADDR_W    = $clog2(BUF_DEPTH);
  localparam int unsigned WPOS_W    = $clog2(BUF_DEPTH + 1);

  // Idle counter
  localparam int unsigned IDLE_W   = 16;
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

  // Frame walk: bytes 0..10 plus check byte 11
  localparam int unsigned RD_IDX_W  = 4;
  localparam logic [RD_IDX_W-1:0] CHECK_IDX = 4'd11;
  localparam int unsigned NUM_BYTES = 12;

  // Configuration
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned GAP_W      = 10;
  localparam int unsigned REARM_W    = 7;
  localparam logic [GAP_W-1:0]   GAP_RESET   = 10'd50;
  localparam logic [REARM_W-1:0] REARM_RESET = 7'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_GAP = 1'b0,
    REG_REARM    = 1'b1
  } cfg_reg_e;

  // Header characters
  localparam logic [7:0] CHR_M = 8'h4D;
  localparam logic [7:0] CHR_S = 8'h53;
  localparam logic [7:0] CHR_W = 8'h57;
  localparam logic [7:0] CHR_P = 8'h50;

  typedef enum logic [1:0] {
    FS_FAIL     = 2'd0,
    FS_START    = 2'd1,
    FS_WAYPOINT = 2'd2,
    FS_OTHER    = 2'd3
  } frame_status_e;

  // Input item
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  localparam logic KIND_BYTE = 1'b0;

  // Result item
  typedef struct packed {
    frame_status_e      frame_status;
    logic [7:0]         start_code;
    logic signed [31:0] wp_latitude;
    logic signed [31:0] wp_longitude;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic                take;      // apply accepted item
    logic                start;     // begin frame walk
    logic                no_check;  // item done without a check
    logic                rd_issue;  // read buffer at rd_idx
    logic [RD_IDX_W-1:0] rd_idx;
    logic                finish;    // build result, reset write position
  } igfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic check_due;
    logic out_free;
  } igfr_sts_t;

endpackage

// ===== hdl/idle_gap_frame_receiver_unit.sv =====
// Top level of the idle-gap frame receiver: joins the sequencer and the datapath.
// Depends on igfr_pkg, igfr_ctrl and igfr_datapath.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  in_item_t (kind, rx_byte)
//   out      output     out_valid_o / out_ready_i out_item_t (status, code, lat, lon)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An item without a frame check passes through accept, then the check decision.
// An item that triggers a check passes through accept, decision, 12 reads of the
// single registered buffer read port, a last step for the final read, and the result.
// Reset clears all control state at once; unwritten buffer entries read as zero.
// A check whose result meets a full output register waits until it is taken.
// Configuration writes are accepted in every cycle.

module idle_gap_frame_receiver_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  igfr_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output igfr_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [igfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [igfr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import igfr_pkg::*;

  igfr_cmd_t cmd;
  igfr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  igfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  igfr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hdl/igfr_ctrl.sv =====
// Sequencer of the idle-gap frame receiver: item accept, check decision, buffer walk.
// Depends on igfr_pkg and the assertion macros header.
`include "idle_gap_frame_receiver_unit_defines.svh"

module igfr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  igfr_pkg::igfr_sts_t sts_i,
  output igfr_pkg::igfr_cmd_t cmd_o
);
  import igfr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_READ   = 5'b00100,
    S_LAST   = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [RD_IDX_W-1:0] rd_idx_q, rd_idx_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    rd_idx_d       = rd_idx_q;
    cmd_o          = '0;
    cmd_o.rd_idx   = rd_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.check_due) begin
          cmd_o.start = 1'b1;
          rd_idx_d    = '0;
          state_d     = S_READ;
        end else begin
          cmd_o.no_check = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (rd_idx_q == CHECK_IDX) begin
          state_d = S_LAST;
        end else begin
          rd_idx_d = rd_idx_q + RD_IDX_W'(1);
        end
      end
      S_LAST: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  `IGFR_ASSERT_IMPL(a_rd_idx_range, state_q == S_READ, rd_idx_q <= CHECK_IDX, "walk index overrun")
  `IGFR_ASSERT_IMPL(a_finish_free, cmd_o.finish, sts_i.out_free, "result built into a full output")
  `IGFR_ASSERT_NEXT(a_last_to_result, state_q == S_LAST, state_q == S_RESULT, "walk tail skipped")

endmodule

// ===== hdl/igfr_datapath.sv =====
// Datapath of the idle-gap frame receiver: frame buffer, counters, config, result register.
// Depends on igfr_pkg and the assertion macros header.
`include "idle_gap_frame_receiver_unit_defines.svh"

module igfr_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  igfr_pkg::in_item_t             in_item_i,
  input  logic                           cfg_valid_i,
  input  logic [igfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [igfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  igfr_pkg::igfr_cmd_t            cmd_i,
  output igfr_pkg::igfr_sts_t            sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output igfr_pkg::out_item_t            out_item_o
);
  import igfr_pkg::*;

  logic [7:0]          buf_mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] vld_q, vld_d;
  logic [WPOS_W-1:0]   wpos_q, wpos_d, wpos_clamp;
  logic [IDLE_W-1:0]   idle_q, idle_d;
  logic                done_q, done_d;
  logic [GAP_W-1:0]    gap_q;
  logic [REARM_W-1:0]  rearm_q;
  logic [7:0]          rd_byte_q;
  logic                rd_vld_q;
  logic                cap_q;
  logic [7:0]          rd_data;
  logic [7:0]          bytes_q [NUM_BYTES];
  logic [7:0]          xor_q;
  logic                out_valid_q;
  out_item_t           out_q, result;
  logic                below_rearm;
  logic                is_wp;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q   <= GAP_RESET;
      rearm_q <= REARM_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IDLE_GAP: gap_q   <= cfg_data_i[GAP_W-1:0];
        REG_REARM:    rearm_q <= cfg_data_i[REARM_W-1:0];
        default: ;
      endcase
    end
  end

  // Write position clamps to the last slot when the buffer is full
  assign wpos_clamp = (wpos_q >= WPOS_W'(BUF_DEPTH)) ? WPOS_W'(BUF_DEPTH - 1) : wpos_q;
  assign wr_addr    = wpos_clamp[ADDR_W-1:0];
  assign wr_en      = cmd_i.take && (in_item_i.kind == KIND_BYTE);
  assign rd_addr    = ADDR_W'(cmd_i.rd_idx);

  assign below_rearm     = idle_q < IDLE_W'(rearm_q);
  assign sts_o.check_due = (idle_q > IDLE_W'(gap_q)) && !done_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Frame buffer storage and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= in_item_i.rx_byte;
    end
    if (cmd_i.rd_issue) begin
      rd_byte_q <= buf_mem[rd_addr];
    end
  end

  // Entries never written read as zero
  assign rd_data = rd_vld_q ? rd_byte_q : 8'h00;

  // Result of the check from captured bytes
  assign is_wp = (bytes_q[0] == CHR_W) && (bytes_q[1] == CHR_P);

  always_comb begin
    result = '0;
    if (xor_q != 8'h00) begin
      result.frame_status = FS_FAIL;
    end else if ((bytes_q[0] == CHR_M) && (bytes_q[1] == CHR_S)) begin
      result.frame_status = FS_START;
      result.start_code   = bytes_q[2];
    end else if (is_wp) begin
      result.frame_status = FS_WAYPOINT;
      result.wp_latitude  = {bytes_q[5], bytes_q[4], bytes_q[3], bytes_q[2]};
      result.wp_longitude = {bytes_q[9], bytes_q[8], bytes_q[7], bytes_q[6]};
    end else begin
      result.frame_status = FS_OTHER;
    end
  end

  // Control state next values
  always_comb begin
    vld_d  = vld_q;
    wpos_d = wpos_q;
    idle_d = idle_q;
    done_d = done_q;
    if (cmd_i.take) begin
      if (in_item_i.kind == KIND_BYTE) begin
        vld_d[wr_addr] = 1'b1;
        wpos_d         = wpos_clamp + WPOS_W'(1);
        idle_d         = '0;
      end else if (idle_q != IDLE_MAX) begin
        idle_d = idle_q + IDLE_W'(1);
      end
    end
    if (cmd_i.no_check) begin
      done_d = done_q && !below_rearm;
    end
    if (cmd_i.finish) begin
      wpos_d = '0;
      done_d = !below_rearm;
      // drop byte 0 of a waypoint frame
      if ((xor_q == 8'h00) && is_wp) begin
        vld_d[0] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      wpos_q      <= '0;
      idle_q      <= '0;
      done_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      wpos_q <= wpos_d;
      idle_q <= idle_d;
      done_q <= done_d;
      cap_q  <= cmd_i.rd_issue;
      if (cmd_i.rd_issue) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shift in walked bytes and fold the XOR over all twelve
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      xor_q <= 8'h00;
    end else if (cap_q) begin
      xor_q <= xor_q ^ rd_data;
    end
    if (cap_q) begin
      for (int i = 0; i < NUM_BYTES - 1; i++) begin
        bytes_q[i] <= bytes_q[i+1];
      end
      bytes_q[NUM_BYTES-1] <= rd_data;
    end
    if (cmd_i.finish) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `IGFR_ASSERT_IMPL(a_wpos_range, 1'b1, wpos_q <= WPOS_W'(BUF_DEPTH), "write position overrun")
  `IGFR_ASSERT_NEXT(a_finish_valid, cmd_i.finish, out_valid_q, "result not presented")
  `IGFR_ASSERT_NEXT(a_finish_wpos, cmd_i.finish, wpos_q == '0, "write position not reset")

endmodule
